// File: rtl/html_esc_pkg.sv
// Package for the HTML entity escaper: entity codes and the entity
// character table. No dependencies.
`default_nettype none

package html_esc_pkg;

  // Byte codes of the special characters
  localparam logic [7:0] ChQuot = 8'h22;
  localparam logic [7:0] ChApos = 8'h27;
  localparam logic [7:0] ChLt   = 8'h3C;
  localparam logic [7:0] ChGt   = 8'h3E;
  localparam logic [7:0] ChAmp  = 8'h26;
  localparam logic [7:0] ChBsol = 8'h5C;
  localparam logic [7:0] ChNul  = 8'h00;

  // Which replacement a source byte takes; ENT_NONE is a plain byte
  typedef enum logic [2:0] {
    ENT_NONE,
    ENT_QUOT,
    ENT_APOS,
    ENT_LT,
    ENT_GT,
    ENT_AMP,
    ENT_BSOL
  } ent_e;

  typedef logic [2:0] ent_idx_t;

  function automatic ent_e ent_of(input logic [7:0] c);
    ent_e e;
    unique case (c)
      ChQuot:  e = ENT_QUOT;
      ChApos:  e = ENT_APOS;
      ChLt:    e = ENT_LT;
      ChGt:    e = ENT_GT;
      ChAmp:   e = ENT_AMP;
      ChBsol:  e = ENT_BSOL;
      default: e = ENT_NONE;
    endcase
    return e;
  endfunction

  // Number of output bytes for an item of the given kind
  function automatic ent_idx_t ent_len(input ent_e e);
    ent_idx_t n;
    unique case (e)
      ENT_QUOT, ENT_APOS, ENT_BSOL: n = 3'd6;
      ENT_LT, ENT_GT:               n = 3'd4;
      ENT_AMP:                      n = 3'd5;
      default:                      n = 3'd1;
    endcase
    return n;
  endfunction

  // Character at position idx of an entity
  function automatic logic [7:0] ent_char(input ent_e e, input ent_idx_t idx);
    logic [7:0] ch;
    ch = 8'h3F;
    if (idx == 3'd0) begin
      ch = "&";
    end else begin
      unique case (e)
        ENT_QUOT: begin
          unique case (idx)
            3'd1: ch = "q";
            3'd2: ch = "u";
            3'd3: ch = "o";
            3'd4: ch = "t";
            default: ch = ";";
          endcase
        end
        ENT_APOS: begin
          unique case (idx)
            3'd1: ch = "a";
            3'd2: ch = "p";
            3'd3: ch = "o";
            3'd4: ch = "s";
            default: ch = ";";
          endcase
        end
        ENT_BSOL: begin
          unique case (idx)
            3'd1: ch = "b";
            3'd2: ch = "s";
            3'd3: ch = "o";
            3'd4: ch = "l";
            default: ch = ";";
          endcase
        end
        ENT_LT: begin
          unique case (idx)
            3'd1: ch = "l";
            3'd2: ch = "t";
            default: ch = ";";
          endcase
        end
        ENT_GT: begin
          unique case (idx)
            3'd1: ch = "g";
            3'd2: ch = "t";
            default: ch = ";";
          endcase
        end
        ENT_AMP: begin
          unique case (idx)
            3'd1: ch = "a";
            3'd2: ch = "m";
            3'd3: ch = "p";
            default: ch = ";";
          endcase
        end
        default: ch = 8'h3F;
      endcase
    end
    return ch;
  endfunction

endpackage

`default_nettype wire

// File: rtl/html_entity_escape.sv
// Top level of the HTML entity escaper: fit check, write count and the
// output register that plays out entity bytes. Depends on html_esc_pkg.
//
// channel | direction | handshake           | payload
// src     | in        | src_valid_i/stall_o | src_byte_i
// out     | out       | out_valid_o/stall_i | out_byte_o, run_last_o, truncated_o
// cfg     | in        | cfg_valid_i/ready_o | cfg_dest_size_i
//
// A plain byte or the terminator puts a single byte in the output register;
// an entity of L bytes holds it, stalling the source, until all L have left.
// Dropped bytes are taken one per cycle while the source is not stalled. The
// output register is the only stage: a request is taken while the last byte
// of the previous one leaves. Reset clears the count, the flag and the output
// valid; dest_size is 4096. cfg_ready_o is always high.
`default_nettype none

module html_entity_escape #(
  parameter int COUNT_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        src_valid_i,
  output logic             src_stall_o,
  input  wire logic [7:0]  src_byte_i,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [15:0] cfg_dest_size_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       out_byte_o,
  output logic             run_last_o,
  output logic             truncated_o
);

  localparam int SumBits = ((COUNT_BITS > 16) ? COUNT_BITS : 16) + 1;
  localparam logic [COUNT_BITS-1:0] CountMax = {COUNT_BITS{1'b1}};

  // Configuration register
  logic [15:0] dest_size_q;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dest_size_q <= 16'd4096;
    end else if (cfg_valid_i) begin
      dest_size_q <= cfg_dest_size_i;
    end
  end

  // String state
  logic [COUNT_BITS-1:0] count_q, count_d;
  logic                  trunc_q, trunc_d;

  // Output register
  logic                   valid_q, valid_d;
  html_esc_pkg::ent_e     kind_q, kind_d;
  logic [7:0]             byte_q, byte_d;
  html_esc_pkg::ent_idx_t len_q, len_d;
  html_esc_pkg::ent_idx_t idx_q, idx_d;
  logic                   otrunc_q, otrunc_d;

  logic last_byte, out_pop, src_acc;

  assign last_byte   = (idx_q == len_q - 3'd1);
  assign out_pop     = valid_q && !out_stall_i;
  assign src_stall_o = valid_q && !(last_byte && !out_stall_i);
  assign src_acc     = src_valid_i && !src_stall_o;

  // Decode and fit check of the incoming byte
  html_esc_pkg::ent_e     in_kind;
  html_esc_pkg::ent_idx_t in_len;
  html_esc_pkg::ent_idx_t in_extra;
  logic [SumBits-1:0]     need;
  logic                   fits;
  logic [COUNT_BITS:0]    count_sum;
  logic [COUNT_BITS-1:0]  count_sat;

  always_comb begin
    in_kind   = html_esc_pkg::ent_of(src_byte_i);
    in_len    = html_esc_pkg::ent_len(in_kind);
    // an entity needs its length plus two, a plain byte needs two
    in_extra  = (in_kind == html_esc_pkg::ENT_NONE) ? 3'd0 : in_len;
    need      = SumBits'(count_q) + SumBits'(in_extra) + SumBits'(2);
    fits      = (need <= SumBits'(dest_size_q));
    count_sum = {1'b0, count_q} + (COUNT_BITS+1)'(in_len);
    count_sat = count_sum[COUNT_BITS] ? CountMax : count_sum[COUNT_BITS-1:0];
  end

  // Next state
  always_comb begin
    count_d  = count_q;
    trunc_d  = trunc_q;
    valid_d  = valid_q;
    kind_d   = kind_q;
    byte_d   = byte_q;
    len_d    = len_q;
    idx_d    = idx_q;
    otrunc_d = otrunc_q;

    // drain the output register
    if (out_pop) begin
      if (last_byte) begin
        valid_d = 1'b0;
      end else begin
        idx_d = idx_q + 3'd1;
      end
    end

    // take a request
    if (src_acc) begin
      priority if (src_byte_i == html_esc_pkg::ChNul) begin
        valid_d  = 1'b1;
        kind_d   = html_esc_pkg::ENT_NONE;
        byte_d   = html_esc_pkg::ChNul;
        len_d    = 3'd1;
        idx_d    = 3'd0;
        otrunc_d = trunc_q;
        count_d  = '0;
        trunc_d  = 1'b0;
      end else if (trunc_q) begin
        // dropped after truncation
      end else if (!fits) begin
        trunc_d = 1'b1;
      end else begin
        valid_d  = 1'b1;
        kind_d   = in_kind;
        byte_d   = src_byte_i;
        len_d    = in_len;
        idx_d    = 3'd0;
        otrunc_d = 1'b0;
        count_d  = count_sat;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      trunc_q <= 1'b0;
      valid_q <= 1'b0;
      idx_q   <= '0;
      len_q   <= 3'd1;
    end else begin
      count_q <= count_d;
      trunc_q <= trunc_d;
      valid_q <= valid_d;
      idx_q   <= idx_d;
      len_q   <= len_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    kind_q   <= kind_d;
    byte_q   <= byte_d;
    otrunc_q <= otrunc_d;
  end

  // Output drive
  assign out_valid_o = valid_q;
  assign out_byte_o  = (kind_q == html_esc_pkg::ENT_NONE) ? byte_q
                       : html_esc_pkg::ent_char(kind_q, idx_q);
  assign run_last_o  = last_byte;
  assign truncated_o = otrunc_q;

  // Checks
  a_mid_entity_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !last_byte |-> src_stall_o)
    else $error("source taken while an entity is still playing out");

  a_term_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    src_acc && (src_byte_i == html_esc_pkg::ChNul) |=> (count_q == '0) && !trunc_q)
    else $error("terminator did not clear count and flag");

  a_idx_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_pop && !last_byte |=> valid_q && (idx_q == $past(idx_q) + 3'd1))
    else $error("entity byte index did not advance");

endmodule

`default_nettype wire
